/* rtl/mrmp_pkg.sv */
// shared types, constants and the crc step for the meter poller
package mrmp_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int MIN_FRAME     = 35;
    localparam int BC_W          = $clog2(MAX_FRAME_LEN + 2);

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // register indexes
    localparam logic [1:0] REG_DEVICE_ID     = 2'd0;
    localparam logic [1:0] REG_POLL_DELAY    = 2'd1;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd2;

    localparam logic [7:0]  RST_DEVICE_ID     = 8'd1;
    localparam logic [15:0] RST_POLL_DELAY    = 16'd50;
    localparam logic [15:0] RST_REPLY_TIMEOUT = 16'd500;

    // input opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_DONE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_ID      = 2'd3;

    // request frame constants
    localparam logic [7:0] FUNC_READ_HOLD = 8'h03;
    localparam logic [7:0] START_HI       = 8'h00;
    localparam logic [7:0] START_LO       = 8'h48;
    localparam logic [7:0] COUNT_HI       = 8'h00;
    localparam logic [7:0] COUNT_LO       = 8'h08;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [2:0] REQ_CRC_LO = 3'd6;
    localparam logic [2:0] REQ_LAST   = 3'd7;
    localparam logic [2:0] WORD_LAST  = 3'd6;
    localparam logic [2:0] WORD_GAP   = 3'd5;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [15:0] poll_delay;
        logic [15:0] reply_timeout;
    } t_cfg;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_REQ,
        EV_WORDS,
        EV_STAT
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_RD,
        S_WORD,
        S_STAT
    } t_state;

    typedef struct packed {
        logic       take;
        logic       load_req;
        logic       rd;
        logic       load_word;
        logic       load_stat;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        t_event ev;
        logic   slot_free;
    } t_sts;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // words sit at frame bytes 3..22 and 27..34, four bytes to a row
    function automatic logic [2:0] word_row(input logic [2:0] idx);
        return (idx < WORD_GAP) ? idx : idx + 3'd1;
    endfunction

endpackage

/* rtl/modbus_rtu_meter_poller_top.sv */
// top level of the modbus rtu meter poller
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   i_opcode, i_rx_byte
//  out       source     o_out_valid / i_out_stall o_kind .. o_last
//  cfg       apb slave  psel, penable, pready     paddr, pwdata, prdata
//
// a tick, byte or frame end that yields nothing is taken without stalling the input
// a poll request: eight output beats, one per cycle when not stalled
// a good reply: seven words, each read from the registered payload memory before its beat,
//   and one status beat; a bad reply or timeout one status beat
// input is stalled while results are being sequenced; output stalls just hold the
//   result register, synchronous active-low reset, no clearing pass
module modbus_rtu_meter_poller_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_tx_byte,
    output logic [2:0]                   o_word_index,
    output logic [31:0]                  o_word_value,
    output logic [1:0]                   o_status,
    output logic                         o_timeout_flag,
    output logic                         o_comm_error_flag,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrmp_pkg::CFG_AW-1:0]  paddr,
    input  logic [mrmp_pkg::CFG_DW-1:0]  pwdata,
    output logic [mrmp_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);

    mrmp_pkg::t_cfg cfg;
    mrmp_pkg::t_cmd cmd;
    mrmp_pkg::t_sts sts;

    mrmp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mrmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mrmp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_in_valid        (i_in_valid),
        .i_opcode          (i_opcode),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_tx_byte         (o_tx_byte),
        .o_word_index      (o_word_index),
        .o_word_value      (o_word_value),
        .o_status          (o_status),
        .o_timeout_flag    (o_timeout_flag),
        .o_comm_error_flag (o_comm_error_flag),
        .o_last            (o_last)
    );

    // words only follow a good reply, which clears both sticky flags
    a_word_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == mrmp_pkg::KIND_WORD |-> !o_timeout_flag && !o_comm_error_flag)
        else $error("measurement word with a sticky flag set");

    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == mrmp_pkg::KIND_STAT |-> o_last)
        else $error("status beat not marked last");

    a_word_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == mrmp_pkg::KIND_WORD |-> !o_last && o_word_index <= 3'd6)
        else $error("bad measurement word beat");

    a_busy_after_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take && sts.ev != mrmp_pkg::EV_NONE |=> o_in_stall)
        else $error("input not stalled while results are pending");

endmodule

/* rtl/mrmp_regs.sv */
// configuration registers behind the apb-style port
module mrmp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrmp_pkg::CFG_AW-1:0]   paddr,
    input  logic [mrmp_pkg::CFG_DW-1:0]   pwdata,
    output logic [mrmp_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output mrmp_pkg::t_cfg                o_cfg
);

    logic [7:0]  r_device_id;
    logic [15:0] r_poll_delay;
    logic [15:0] r_reply_timeout;
    logic        wr;
    logic [1:0]  sel;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign sel    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id     <= mrmp_pkg::RST_DEVICE_ID;
            r_poll_delay    <= mrmp_pkg::RST_POLL_DELAY;
            r_reply_timeout <= mrmp_pkg::RST_REPLY_TIMEOUT;
        end else if (wr) begin
            unique case (sel)
                mrmp_pkg::REG_DEVICE_ID:     r_device_id     <= pwdata[7:0];
                mrmp_pkg::REG_POLL_DELAY:    r_poll_delay    <= pwdata[15:0];
                mrmp_pkg::REG_REPLY_TIMEOUT: r_reply_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            mrmp_pkg::REG_DEVICE_ID:     prdata = {24'h0, r_device_id};
            mrmp_pkg::REG_POLL_DELAY:    prdata = {16'h0, r_poll_delay};
            mrmp_pkg::REG_REPLY_TIMEOUT: prdata = {16'h0, r_reply_timeout};
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg = '{device_id: r_device_id, poll_delay: r_poll_delay,
                     reply_timeout: r_reply_timeout};

endmodule

/* rtl/mrmp_datapath.sv */
// receive state, tick counter, payload memory, request crc and result register
module mrmp_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrmp_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    input  logic [1:0]      i_opcode,
    input  logic [7:0]      i_rx_byte,
    input  mrmp_pkg::t_cmd  i_cmd,
    output mrmp_pkg::t_sts  o_sts,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_tx_byte,
    output logic [2:0]      o_word_index,
    output logic [31:0]     o_word_value,
    output logic [1:0]      o_status,
    output logic            o_timeout_flag,
    output logic            o_comm_error_flag,
    output logic            o_last
);

    localparam int BC_W = mrmp_pkg::BC_W;

    logic                r_awaiting;
    logic [15:0]         r_elapsed;
    logic [BC_W-1:0]     r_bc;
    logic [15:0]         r_crc;
    logic [15:0]         r_tail;
    logic [7:0]          r_first;
    logic                r_timeout_seen;
    logic                r_error_seen;
    logic [1:0]          r_stat;
    logic [15:0]         r_tx_crc;
    logic [31:0]         r_mem [8];
    logic [31:0]         r_rdata;

    logic                r_out_valid;
    logic [1:0]          r_kind;
    logic [7:0]          r_tx_byte;
    logic [2:0]          r_word_index;
    logic [31:0]         r_word_value;
    logic [1:0]          r_status;
    logic                r_tflag;
    logic                r_eflag;
    logic                r_last;

    logic [15:0]         elapsed_inc;
    logic [1:0]          verdict;
    logic [BC_W-1:0]     off_full;
    logic [4:0]          off;
    logic                store_wr;
    logic [7:0]          req_byte;
    mrmp_pkg::t_event    ev;
    logic                slot_free;

    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    // address, then length, then crc
    always_comb begin
        if (r_bc == '0 || r_first != i_cfg.device_id) begin
            verdict = mrmp_pkg::ST_ID;
        end else if (r_bc < BC_W'(mrmp_pkg::MIN_FRAME) ||
                     r_bc > BC_W'(mrmp_pkg::MAX_FRAME_LEN)) begin
            verdict = mrmp_pkg::ST_CRC;
        end else if (r_tail[15:8] != r_crc[7:0] || r_tail[7:0] != r_crc[15:8]) begin
            verdict = mrmp_pkg::ST_CRC;
        end else begin
            verdict = mrmp_pkg::ST_OK;
        end
    end

    always_comb begin
        ev = mrmp_pkg::EV_NONE;
        if (i_in_valid) begin
            unique case (i_opcode)
                mrmp_pkg::OP_TICK: begin
                    if (!r_awaiting) begin
                        if (elapsed_inc >= i_cfg.poll_delay) ev = mrmp_pkg::EV_REQ;
                    end else if (elapsed_inc >= i_cfg.reply_timeout) begin
                        ev = mrmp_pkg::EV_STAT;
                    end
                end
                mrmp_pkg::OP_DONE: begin
                    if (r_awaiting) begin
                        ev = (verdict == mrmp_pkg::ST_OK) ? mrmp_pkg::EV_WORDS
                                                          : mrmp_pkg::EV_STAT;
                    end
                end
                default: ev = mrmp_pkg::EV_NONE;
            endcase
        end
    end

    assign off_full = r_bc - BC_W'(3);
    assign off      = off_full[4:0];
    assign store_wr = i_cmd.take && i_opcode == mrmp_pkg::OP_BYTE && r_awaiting &&
                      r_bc >= BC_W'(3) && r_bc <= BC_W'(34);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting     <= 1'b0;
            r_elapsed      <= '0;
            r_bc           <= '0;
            r_crc          <= mrmp_pkg::CRC_INIT;
            r_tail         <= '0;
            r_first        <= '0;
            r_timeout_seen <= 1'b0;
            r_error_seen   <= 1'b0;
            r_stat         <= mrmp_pkg::ST_OK;
        end else if (i_cmd.take) begin
            unique case (i_opcode)
                mrmp_pkg::OP_TICK: begin
                    if (ev != mrmp_pkg::EV_NONE) begin
                        r_awaiting <= (ev == mrmp_pkg::EV_REQ);
                        r_elapsed  <= '0;
                        r_bc       <= '0;
                        r_crc      <= mrmp_pkg::CRC_INIT;
                        r_tail     <= '0;
                        r_first    <= '0;
                        if (ev == mrmp_pkg::EV_STAT) begin
                            r_timeout_seen <= 1'b1;
                            r_stat         <= mrmp_pkg::ST_TIMEOUT;
                        end
                    end else begin
                        r_elapsed <= elapsed_inc;
                    end
                end
                mrmp_pkg::OP_BYTE: begin
                    if (r_awaiting) begin
                        // crc lags two bytes so it ends short of the check bytes
                        if (r_bc >= BC_W'(2)) r_crc <= mrmp_pkg::crc_byte(r_crc, r_tail[15:8]);
                        r_tail <= {r_tail[7:0], i_rx_byte};
                        if (r_bc == '0) r_first <= i_rx_byte;
                        if (r_bc <= BC_W'(mrmp_pkg::MAX_FRAME_LEN)) r_bc <= r_bc + BC_W'(1);
                    end
                end
                mrmp_pkg::OP_DONE: begin
                    if (r_awaiting) begin
                        r_stat     <= verdict;
                        r_awaiting <= 1'b0;
                        r_elapsed  <= '0;
                        r_bc       <= '0;
                        r_crc      <= mrmp_pkg::CRC_INIT;
                        r_tail     <= '0;
                        r_first    <= '0;
                        if (verdict == mrmp_pkg::ST_OK) begin
                            r_timeout_seen <= 1'b0;
                            r_error_seen   <= 1'b0;
                        end else begin
                            r_error_seen <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload memory, big-endian byte lanes
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            unique case (off[1:0])
                2'd0: r_mem[off[4:2]][31:24] <= i_rx_byte;
                2'd1: r_mem[off[4:2]][23:16] <= i_rx_byte;
                2'd2: r_mem[off[4:2]][15:8]  <= i_rx_byte;
                2'd3: r_mem[off[4:2]][7:0]   <= i_rx_byte;
            endcase
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[mrmp_pkg::word_row(i_cmd.idx)];
        end
    end

    always_comb begin
        unique case (i_cmd.idx)
            3'd0: req_byte = i_cfg.device_id;
            3'd1: req_byte = mrmp_pkg::FUNC_READ_HOLD;
            3'd2: req_byte = mrmp_pkg::START_HI;
            3'd3: req_byte = mrmp_pkg::START_LO;
            3'd4: req_byte = mrmp_pkg::COUNT_HI;
            3'd5: req_byte = mrmp_pkg::COUNT_LO;
            3'd6: req_byte = r_tx_crc[7:0];
            3'd7: req_byte = r_tx_crc[15:8];
        endcase
    end

    // request crc folds one byte per beat as the header goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_crc <= mrmp_pkg::CRC_INIT;
        end else if (i_cmd.take && ev == mrmp_pkg::EV_REQ) begin
            r_tx_crc <= mrmp_pkg::CRC_INIT;
        end else if (i_cmd.load_req && i_cmd.idx < mrmp_pkg::REQ_CRC_LO) begin
            r_tx_crc <= mrmp_pkg::crc_byte(r_tx_crc, req_byte);
        end
    end

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_req || i_cmd.load_word || i_cmd.load_stat) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req || i_cmd.load_word || i_cmd.load_stat) begin
            r_tflag      <= r_timeout_seen;
            r_eflag      <= r_error_seen;
            r_tx_byte    <= '0;
            r_word_index <= '0;
            r_word_value <= '0;
            r_status     <= mrmp_pkg::ST_OK;
            r_last       <= 1'b0;
            priority if (i_cmd.load_req) begin
                r_kind    <= mrmp_pkg::KIND_REQ;
                r_tx_byte <= req_byte;
                r_last    <= (i_cmd.idx == mrmp_pkg::REQ_LAST);
            end else if (i_cmd.load_word) begin
                r_kind       <= mrmp_pkg::KIND_WORD;
                r_word_index <= i_cmd.idx;
                r_word_value <= r_rdata;
            end else begin
                r_kind   <= mrmp_pkg::KIND_STAT;
                r_status <= r_stat;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_sts             = '{ev: ev, slot_free: slot_free};
    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_tx_byte         = r_tx_byte;
    assign o_word_index      = r_word_index;
    assign o_word_value      = r_word_value;
    assign o_status          = r_status;
    assign o_timeout_flag    = r_tflag;
    assign o_comm_error_flag = r_eflag;
    assign o_last            = r_last;

endmodule

/* rtl/mrmp_ctrl.sv */
// sequencer for request bytes, measurement words and status beats
module mrmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mrmp_pkg::t_sts  i_sts,
    output mrmp_pkg::t_cmd  o_cmd
);

    mrmp_pkg::t_state r_state, n_state;
    logic [2:0]       r_idx, n_idx;
    logic             take;

    assign take = i_in_valid && r_state == mrmp_pkg::S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrmp_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            mrmp_pkg::S_IDLE: begin
                n_idx = '0;
                if (take) begin
                    unique case (i_sts.ev)
                        mrmp_pkg::EV_REQ:   n_state = mrmp_pkg::S_REQ;
                        mrmp_pkg::EV_WORDS: n_state = mrmp_pkg::S_RD;
                        mrmp_pkg::EV_STAT:  n_state = mrmp_pkg::S_STAT;
                        mrmp_pkg::EV_NONE:  n_state = mrmp_pkg::S_IDLE;
                    endcase
                end
            end
            mrmp_pkg::S_REQ: begin
                if (i_sts.slot_free) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == mrmp_pkg::REQ_LAST) n_state = mrmp_pkg::S_IDLE;
                end
            end
            mrmp_pkg::S_RD: n_state = mrmp_pkg::S_WORD;
            mrmp_pkg::S_WORD: begin
                if (i_sts.slot_free) begin
                    n_idx   = r_idx + 3'd1;
                    n_state = (r_idx == mrmp_pkg::WORD_LAST) ? mrmp_pkg::S_STAT
                                                             : mrmp_pkg::S_RD;
                end
            end
            mrmp_pkg::S_STAT: begin
                if (i_sts.slot_free) n_state = mrmp_pkg::S_IDLE;
            end
            default: n_state = mrmp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_idx;
        o_cmd.take      = take;
        o_cmd.load_req  = (r_state == mrmp_pkg::S_REQ)  && i_sts.slot_free;
        o_cmd.rd        = (r_state == mrmp_pkg::S_RD);
        o_cmd.load_word = (r_state == mrmp_pkg::S_WORD) && i_sts.slot_free;
        o_cmd.load_stat = (r_state == mrmp_pkg::S_STAT) && i_sts.slot_free;
    end

    assign o_in_stall = (r_state != mrmp_pkg::S_IDLE);

endmodule

/* bench/tb.sv */
// self-checking bench for the modbus rtu meter poller: directed rows, then random polls
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 65;
    localparam int DIR_POLL       = 8;
    localparam int DIR_LIMIT      = 20;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [2:0]  idx;
        logic [31:0] val;
        logic [1:0]  status;
        logic        tflag;
        logic        eflag;
        logic        last;
    } t_meter_beat;

    typedef struct {
        logic [1:0] op;
        logic [7:0] b;
        int         reps;
        bit         chk;
        logic [1:0] kind;
        logic [1:0] status;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [1:0]                     i_opcode;
    logic [7:0]                     i_rx_byte;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [1:0]                     o_kind;
    logic [7:0]                     o_tx_byte;
    logic [2:0]                     o_word_index;
    logic [31:0]                    o_word_value;
    logic [1:0]                     o_status;
    logic                           o_timeout_flag;
    logic                           o_comm_error_flag;
    logic                           o_last;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mrmp_pkg::CFG_AW-1:0]    paddr;
    logic [mrmp_pkg::CFG_DW-1:0]    pwdata;
    logic [mrmp_pkg::CFG_DW-1:0]    prdata;
    logic                           pready;

    modbus_rtu_meter_poller_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_tx_byte         (o_tx_byte),
        .o_word_index      (o_word_index),
        .o_word_value      (o_word_value),
        .o_status          (o_status),
        .o_timeout_flag    (o_timeout_flag),
        .o_comm_error_flag (o_comm_error_flag),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // poller state as predicted
    logic [7:0]  pred_id       = mrmp_pkg::RST_DEVICE_ID;
    logic [15:0] pred_poll     = mrmp_pkg::RST_POLL_DELAY;
    logic [15:0] pred_limit    = mrmp_pkg::RST_REPLY_TIMEOUT;
    logic        pred_waiting  = 1'b0;
    logic [15:0] pred_ticks    = 16'd0;
    int          pred_rx_count = 0;
    logic [15:0] pred_rx_crc   = mrmp_pkg::CRC_INIT;
    logic [15:0] pred_rx_tail  = 16'd0;
    logic [7:0]  pred_rx_addr  = 8'd0;
    logic [7:0]  pred_payload [32];
    logic        pred_tmo_flag = 1'b0;
    logic        pred_err_flag = 1'b0;

    t_meter_beat due_beats [$];
    t_stim_row   directed_rows [22];

    int fails        = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    bit hold_ask     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
        logic [15:0] x;
        x = acc ^ {8'h00, d};
        repeat (8) x = x[0] ? ((x >> 1) ^ mrmp_pkg::CRC_POLY) : (x >> 1);
        return x;
    endfunction

    function automatic void rx_clear();
        pred_rx_count = 0;
        pred_rx_crc   = mrmp_pkg::CRC_INIT;
        pred_rx_tail  = 16'd0;
        pred_rx_addr  = 8'd0;
    endfunction

    function automatic t_meter_beat mk_beat(logic [1:0] kind, logic [7:0] tx, logic [2:0] idx,
                                            logic [31:0] val, logic [1:0] st);
        t_meter_beat r;
        r.kind   = kind;
        r.tx     = tx;
        r.idx    = idx;
        r.val    = val;
        r.status = st;
        r.tflag  = pred_tmo_flag;
        r.eflag  = pred_err_flag;
        r.last   = 1'b0;
        return r;
    endfunction

    // works out the beats one accepted item causes; a checked row pins kind and status
    function automatic void poller_step(logic [1:0] op, logic [7:0] b, bit chk,
                                        logic [1:0] ck_kind, logic [1:0] ck_st);
        t_meter_beat outs [8];
        logic [7:0]  req [8];
        logic [15:0] c;
        logic [1:0]  st;
        int          n;
        int          k;
        int          o;
        n = 0;
        case (op)
            mrmp_pkg::OP_TICK: begin
                if (pred_ticks != 16'hFFFF) pred_ticks++;
                if (!pred_waiting) begin
                    if (pred_ticks >= pred_poll) begin
                        req[0] = pred_id;
                        req[1] = mrmp_pkg::FUNC_READ_HOLD;
                        req[2] = mrmp_pkg::START_HI;
                        req[3] = mrmp_pkg::START_LO;
                        req[4] = mrmp_pkg::COUNT_HI;
                        req[5] = mrmp_pkg::COUNT_LO;
                        c = mrmp_pkg::CRC_INIT;
                        for (k = 0; k < 6; k++) c = crc16_step(c, req[k]);
                        req[6] = c[7:0];
                        req[7] = c[15:8];
                        pred_waiting = 1'b1;
                        pred_ticks   = 16'd0;
                        rx_clear();
                        for (k = 0; k < 8; k++) begin
                            outs[n] = mk_beat(mrmp_pkg::KIND_REQ, req[k], 3'd0, 32'd0,
                                              mrmp_pkg::ST_OK);
                            n++;
                        end
                    end
                end else if (pred_ticks >= pred_limit) begin
                    pred_tmo_flag = 1'b1;
                    pred_waiting  = 1'b0;
                    pred_ticks    = 16'd0;
                    rx_clear();
                    outs[n] = mk_beat(mrmp_pkg::KIND_STAT, 8'd0, 3'd0, 32'd0,
                                      mrmp_pkg::ST_TIMEOUT);
                    n++;
                end
            end
            mrmp_pkg::OP_BYTE: begin
                if (pred_waiting) begin
                    // crc trails two bytes so the tail holds the received checksum
                    if (pred_rx_count >= 2) begin
                        pred_rx_crc = crc16_step(pred_rx_crc, pred_rx_tail[15:8]);
                    end
                    pred_rx_tail = {pred_rx_tail[7:0], b};
                    if (pred_rx_count == 0) pred_rx_addr = b;
                    if (pred_rx_count >= 3 && pred_rx_count <= 34) begin
                        pred_payload[pred_rx_count - 3] = b;
                    end
                    if (pred_rx_count <= mrmp_pkg::MAX_FRAME_LEN) pred_rx_count++;
                end
            end
            mrmp_pkg::OP_DONE: begin
                if (pred_waiting) begin
                    if (pred_rx_count == 0 || pred_rx_addr != pred_id) begin
                        st = mrmp_pkg::ST_ID;
                    end else if (pred_rx_count < mrmp_pkg::MIN_FRAME ||
                                 pred_rx_count > mrmp_pkg::MAX_FRAME_LEN) begin
                        st = mrmp_pkg::ST_CRC;
                    end else if (pred_rx_tail[15:8] != pred_rx_crc[7:0] ||
                                 pred_rx_tail[7:0] != pred_rx_crc[15:8]) begin
                        st = mrmp_pkg::ST_CRC;
                    end else begin
                        st = mrmp_pkg::ST_OK;
                    end
                    if (st == mrmp_pkg::ST_OK) begin
                        pred_tmo_flag = 1'b0;
                        pred_err_flag = 1'b0;
                        for (k = 0; k < 7; k++) begin
                            // four payload bytes skipped between energy and temperature
                            o = (k < 5) ? 4 * k : 4 * k + 4;
                            outs[n] = mk_beat(mrmp_pkg::KIND_WORD, 8'd0, 3'(k),
                                              {pred_payload[o], pred_payload[o + 1],
                                               pred_payload[o + 2], pred_payload[o + 3]},
                                              mrmp_pkg::ST_OK);
                            n++;
                        end
                    end else begin
                        pred_err_flag = 1'b1;
                    end
                    outs[n] = mk_beat(mrmp_pkg::KIND_STAT, 8'd0, 3'd0, 32'd0, st);
                    n++;
                    pred_waiting = 1'b0;
                    pred_ticks   = 16'd0;
                    rx_clear();
                end
            end
            default: begin
            end
        endcase
        if (chk) begin
            if (n == 0) begin
                $error("checked row gave no result: opcode %0d", op);
                fails++;
            end else begin
                outs[n - 1].kind   = ck_kind;
                outs[n - 1].status = ck_st;
            end
        end
        for (k = 0; k < n; k++) begin
            if (k == n - 1) outs[k].last = 1'b1;
            due_beats.push_back(outs[k]);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_meter_beat w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_beats.size() == 0) begin
                $error("unexpected beat: kind %0d status %0d", o_kind, o_status);
                fails++;
            end else begin
                w = due_beats.pop_front();
                check_field("kind", 32'(w.kind), 32'(o_kind));
                check_field("tx_byte", 32'(w.tx), 32'(o_tx_byte));
                check_field("word_index", 32'(w.idx), 32'(o_word_index));
                check_field("word_value", w.val, o_word_value);
                check_field("status", 32'(w.status), 32'(o_status));
                check_field("timeout_flag", 32'(w.tflag), 32'(o_timeout_flag));
                check_field("comm_error_flag", 32'(w.eflag), 32'(o_comm_error_flag));
                check_field("last", 32'(w.last), 32'(o_last));
            end
        end
    end

    // receiver side: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] b, bit chk,
                             logic [1:0] ck_kind, logic [1:0] ck_st);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (op == mrmp_pkg::OP_TICK || (pred_waiting && op != OP_SPARE)) items_sent++;
        poller_step(op, b, chk, ck_kind, ck_st);
    endtask

    task automatic send(logic [1:0] op, logic [7:0] b);
        send_item(op, b, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK);
    endtask

    // stop offering input items and let the block run dry
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(logic wr, logic [1:0] idx, logic [31:0] wd, output logic [31:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(logic [1:0] idx, logic [31:0] want);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (idx == mrmp_pkg::REG_DEVICE_ID) ? 32'h0000_00FF : 32'h0000_FFFF;
        apb_xfer(1'b0, idx, 32'd0, rd);
        if ((rd & mask) !== (want & mask)) begin
            $error("register %0d: expected %0h, got %0h", idx, want & mask, rd & mask);
            fails++;
        end
    endtask

    task automatic reg_set(logic [1:0] idx, logic [31:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, v, rd);
        case (idx)
            mrmp_pkg::REG_DEVICE_ID:  pred_id    = v[7:0];
            mrmp_pkg::REG_POLL_DELAY: pred_poll  = v[15:0];
            default:                  pred_limit = v[15:0];
        endcase
        reg_check(idx, v);
    endtask

    task automatic new_setting(logic [7:0] id, logic [15:0] poll, logic [15:0] limit,
                               int gap, int stall);
        settle();
        reg_set(mrmp_pkg::REG_DEVICE_ID, 32'(id));
        reg_set(mrmp_pkg::REG_POLL_DELAY, 32'(poll));
        reg_set(mrmp_pkg::REG_REPLY_TIMEOUT, 32'(limit));
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    task automatic tick_to_request(bit noisy);
        while (!pred_waiting) begin
            if (noisy && $urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 2))
                    0:       send(mrmp_pkg::OP_BYTE, 8'($urandom));
                    1:       send(mrmp_pkg::OP_DONE, 8'($urandom));
                    default: send(OP_SPARE, 8'($urandom));
                endcase
            end else begin
                send(mrmp_pkg::OP_TICK, 8'($urandom));
            end
        end
    endtask

    // one reply frame followed by frame end; a bad crc flips one bit of the checksum
    task automatic reply_frame(int len, bit good_crc, logic [7:0] addr, int fill, bit noisy);
        logic [7:0]  fr [300];
        logic [15:0] c;
        int          k;
        for (k = 0; k < len; k++) begin
            case (fill)
                FILL_ZERO: fr[k] = 8'h00;
                FILL_ONES: fr[k] = 8'hFF;
                default:   fr[k] = 8'($urandom);
            endcase
        end
        if (len > 0) fr[0] = addr;
        if (len >= 3) begin
            c = mrmp_pkg::CRC_INIT;
            for (k = 0; k < len - 2; k++) c = crc16_step(c, fr[k]);
            fr[len - 2] = c[7:0];
            fr[len - 1] = c[15:8];
            if (!good_crc) fr[len - 1] = fr[len - 1] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (k = 0; k < len; k++) begin
            if (noisy && $urandom_range(0, 99) < 3) send(mrmp_pkg::OP_TICK, 8'($urandom));
            send(mrmp_pkg::OP_BYTE, fr[k]);
        end
        send(mrmp_pkg::OP_DONE, 8'($urandom));
    endtask

    // one request and one answer of a randomly chosen shape
    task automatic poll_cycle();
        int pick;
        int len;
        int k;
        tick_to_request(1'b1);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            k = $urandom_range(0, 99);
            len = (k < 80) ? 35 : (k < 98) ? $urandom_range(36, 64) : mrmp_pkg::MAX_FRAME_LEN;
            reply_frame(len, 1'b1, pred_id, FILL_RANDOM, 1'b1);
        end else if (pick < 63) begin
            reply_frame($urandom_range(35, 40), 1'b0, pred_id, FILL_RANDOM, 1'b1);
        end else if (pick < 70) begin
            reply_frame(35, 1'b1, pred_id ^ 8'($urandom_range(1, 255)), FILL_RANDOM, 1'b1);
        end else if (pick < 77) begin
            reply_frame($urandom_range(1, 34), 1'b1, pred_id, FILL_RANDOM, 1'b1);
        end else if (pick < 81) begin
            reply_frame($urandom_range(mrmp_pkg::MAX_FRAME_LEN + 1, mrmp_pkg::MAX_FRAME_LEN + 6),
                        1'b1, pred_id, FILL_RANDOM, 1'b0);
        end else if (pick < 86) begin
            send(mrmp_pkg::OP_DONE, 8'($urandom));
        end else if (pick < 93) begin
            while (pred_waiting) send(mrmp_pkg::OP_TICK, 8'($urandom));
        end else begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++) send(2'($urandom_range(0, 3)), 8'($urandom));
            send(mrmp_pkg::OP_DONE, 8'($urandom));
        end
    endtask

    task automatic random_phase(bit pause_midway);
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if (pause_midway && items_sent - start >= PHASE_ITEMS / 2) begin
                settle();
                pause_midway = 1'b0;
            end
            poll_cycle();
        end
    endtask

    initial begin
        int k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = mrmp_pkg::OP_TICK;
        i_rx_byte  = 8'd0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // device id 1 from reset; short poll and reply limits keep the table brief
        directed_rows = '{
            '{mrmp_pkg::OP_BYTE, 8'h00, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_BYTE, 8'hFF, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_DONE, 8'h00, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{OP_SPARE, 8'hAA, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_POLL - 1, 1'b0, mrmp_pkg::KIND_REQ,
              mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_TICK, 8'hFF, 1, 1'b1, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_DONE, 8'h00, 1, 1'b1, mrmp_pkg::KIND_STAT, mrmp_pkg::ST_ID},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_POLL, 1'b1, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_LIMIT, 1'b1, mrmp_pkg::KIND_STAT,
              mrmp_pkg::ST_TIMEOUT},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_POLL, 1'b1, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_BYTE, 8'h00, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_BYTE, 8'h01, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_DONE, 8'h00, 1, 1'b1, mrmp_pkg::KIND_STAT, mrmp_pkg::ST_ID},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_POLL, 1'b1, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_BYTE, 8'h01, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_BYTE, 8'hFF, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_BYTE, 8'h00, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_DONE, 8'h00, 1, 1'b1, mrmp_pkg::KIND_STAT, mrmp_pkg::ST_CRC},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_POLL, 1'b1, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{OP_SPARE, 8'h55, 1, 1'b0, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK},
            '{mrmp_pkg::OP_DONE, 8'h00, 1, 1'b1, mrmp_pkg::KIND_STAT, mrmp_pkg::ST_ID},
            '{mrmp_pkg::OP_TICK, 8'h00, DIR_POLL, 1'b1, mrmp_pkg::KIND_REQ, mrmp_pkg::ST_OK}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_check(mrmp_pkg::REG_DEVICE_ID, 32'(mrmp_pkg::RST_DEVICE_ID));
        reg_check(mrmp_pkg::REG_POLL_DELAY, 32'(mrmp_pkg::RST_POLL_DELAY));
        reg_check(mrmp_pkg::REG_REPLY_TIMEOUT, 32'(mrmp_pkg::RST_REPLY_TIMEOUT));
        reg_set(mrmp_pkg::REG_POLL_DELAY, 32'(DIR_POLL));
        reg_set(mrmp_pkg::REG_REPLY_TIMEOUT, 32'(DIR_LIMIT));

        foreach (directed_rows[r]) begin
            for (k = 0; k < directed_rows[r].reps; k++) begin
                send_item(directed_rows[r].op, directed_rows[r].b,
                          directed_rows[r].chk && k == directed_rows[r].reps - 1,
                          directed_rows[r].kind, directed_rows[r].status);
            end
        end
        // good replies at both data extremes
        reply_frame(35, 1'b1, pred_id, FILL_ONES, 1'b0);
        tick_to_request(1'b0);
        reply_frame(35, 1'b1, pred_id, FILL_ZERO, 1'b0);

        new_setting(8'h00, 16'd0, 16'd0, 61, 0);
        random_phase(1'b0);

        new_setting(8'hFF, 16'd3, 16'd40, 0, 61);
        // long receiver hold-off while requests keep coming, so the input backs up
        hold_ask = 1'b1;
        random_phase(1'b0);

        new_setting(8'($urandom), 16'd1, 16'd25, 6, 6);
        random_phase(1'b1);

        new_setting(8'($urandom), 16'd2, 16'd15, 0, 0);
        random_phase(1'b0);

        settle();
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
